>>> hdl/assert_macros.svh
// Assertion macros shared by the date difference RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/gdd_pkg.sv
// Package with widths, month tables and control types for the date difference pipeline.
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DOY_W    = 9;
    localparam int DAYS_W   = 23;
    localparam int DIFF_W   = 23;
    localparam int FEB_W    = 2;
    localparam int LEAPS_W  = 13;
    localparam int Q100_W   = 8;
    localparam int R100_W   = 7;

    // Reciprocal of 100 scaled by 2**19; exact floor for all 14-bit years.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5243);
    localparam logic [6:0]         CENTURY     = 7'd100;
    localparam logic [8:0]         COMMON_YEAR = 9'd365;

    localparam logic signed [DIFF_W:0]   DIFF_MAX_WIDE = (DIFF_W+1)'(4194303);
    localparam logic signed [DIFF_W:0]   DIFF_MIN_WIDE = -(DIFF_W+1)'(4194304);
    localparam logic [DIFF_W-1:0]        DIFF_MAX      = DIFF_W'(4194303);
    localparam logic [DIFF_W-1:0]        DIFF_MIN      = DIFF_W'(4194304);

    // Stage load enables and valid bits of the four pipeline stages.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
        logic valid1;
        logic valid2;
        logic valid3;
        logic valid4;
    } pipe_ctrl_t;

    // Days before month m in a common year; months above twelve run on at February length.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            4'd13:   r = 9'd365;
            4'd14:   r = 9'd393;
            4'd15:   r = 9'd421;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // February-length months before month m; each adds a day in a leap year.
    function automatic logic [FEB_W-1:0] febs_before_month(input logic [MONTH_W-1:0] m);
        logic [FEB_W-1:0] r;
        case (m)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd14:            r = 2'd2;
            4'd15:            r = 2'd3;
            default:          r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/gdd_pipe_ctrl.sv
// Valid bits and load enables of the four-stage pipeline.
`timescale 1ns / 1ps

module gdd_pipe_ctrl
    import gdd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       m_tready,
    output pipe_ctrl_t ctrl
);

    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic valid1_next, valid2_next, valid3_next, valid4_next;
    logic load1, load2, load3, load4;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        load4 = !valid4_reg || m_tready;
        load3 = !valid3_reg || load4;
        load2 = !valid2_reg || load3;
        load1 = !valid1_reg || load2;
    end

    // Advance valid bits with the data.
    always_comb begin
        valid1_next = load1 ? s_tvalid   : valid1_reg;
        valid2_next = load2 ? valid1_reg : valid2_reg;
        valid3_next = load3 ? valid2_reg : valid3_reg;
        valid4_next = load4 ? valid3_reg : valid4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end else begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
            valid3_reg <= valid3_next;
            valid4_reg <= valid4_next;
        end
    end

    always_comb begin
        ctrl.load1  = load1;
        ctrl.load2  = load2;
        ctrl.load3  = load3;
        ctrl.load4  = load4;
        ctrl.valid1 = valid1_reg;
        ctrl.valid2 = valid2_reg;
        ctrl.valid3 = valid3_reg;
        ctrl.valid4 = valid4_reg;
    end

endmodule

>>> hdl/gdd_date_count.sv
// Three pipeline stages that turn one date into a running day count and its day of year.
`timescale 1ns / 1ps

module gdd_date_count
    import gdd_pkg::*;
(
    input  logic               aclk,
    input  pipe_ctrl_t         ctrl,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic [DAYS_W-1:0]  total,
    output logic [DOY_W-1:0]   day_of_year
);

    // Stage 1 registers
    logic [YEAR_W-1:0] year_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DAYS_W-1:0] y365_reg, y365_next;
    logic [DOY_W-1:0]  base_reg, base_next;
    logic [FEB_W-1:0]  feb_reg;

    // Stage 2 registers
    logic [DAYS_W-1:0] dby_reg, dby_next;
    logic [DOY_W-1:0]  doy2_reg, doy2_next;

    // Stage 3 registers
    logic [DAYS_W-1:0] total_reg, total_next;
    logic [DOY_W-1:0]  doy3_reg;

    // Stage 2 intermediate terms
    logic [Q100_W-1:0]  q100;
    logic [R100_W-1:0]  r100;
    logic [YEAR_W-1:0]  rem_wide;
    logic               c4, c100, c400, leap;
    logic [LEAPS_W-1:0] leaps;

    // Stage 1: reciprocal product for the century, year times 365, month lookup.
    always_comb begin
        prod_next = PROD_W'(year) * PROD_W'(RECIP_100);
        y365_next = DAYS_W'(year) * DAYS_W'(COMMON_YEAR);
        base_next = days_before_month(month) + DOY_W'(day);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            year_reg <= year;
            prod_reg <= prod_next;
            y365_reg <= y365_next;
            base_reg <= base_next;
            feb_reg  <= febs_before_month(month);
        end
    end

    // Stage 2: century quotient and remainder, leap rule, leap days before the year.
    always_comb begin
        q100     = prod_reg[PROD_W-1 -: Q100_W];
        rem_wide = year_reg - YEAR_W'(q100) * YEAR_W'(CENTURY);
        r100     = rem_wide[R100_W-1:0];
        c4       = |year_reg[1:0];
        c100     = (r100 != '0);
        c400     = c100 || (q100[1:0] != 2'd0);
        leap     = !c4 && !c400 ? 1'b1 : (!c4 && c100);
        leaps    = LEAPS_W'(year_reg[YEAR_W-1:2]) + LEAPS_W'(c4)
                 - LEAPS_W'(q100) - LEAPS_W'(c100)
                 + LEAPS_W'(q100[Q100_W-1:2]) + LEAPS_W'(c400);
        dby_next  = y365_reg + DAYS_W'(leaps);
        doy2_next = base_reg + (leap ? DOY_W'(feb_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            dby_reg  <= dby_next;
            doy2_reg <= doy2_next;
        end
    end

    // Stage 3: running count from year zero.
    always_comb begin
        total_next = dby_reg + DAYS_W'(doy2_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load3) begin
            total_reg <= total_next;
            doy3_reg  <= doy2_reg;
        end
    end

    assign total       = total_reg;
    assign day_of_year = doy3_reg;

endmodule

>>> hdl/gdd_diff.sv
// Output stage: subtract the two day counts, saturate and hold the result.
`timescale 1ns / 1ps

module gdd_diff
    import gdd_pkg::*;
(
    input  logic              aclk,
    input  pipe_ctrl_t        ctrl,
    input  logic [DAYS_W-1:0] first_total,
    input  logic [DAYS_W-1:0] second_total,
    input  logic [DOY_W-1:0]  first_doy,
    input  logic [DOY_W-1:0]  second_doy,
    input  logic              not_later,
    output logic [DIFF_W-1:0] day_difference,
    output logic              first_not_later,
    output logic [DOY_W-1:0]  first_day_of_year,
    output logic [DOY_W-1:0]  second_day_of_year
);

    logic signed [DIFF_W:0] wide;
    logic [DIFF_W-1:0]      diff_reg, diff_next;
    logic                   flag_reg;
    logic [DOY_W-1:0]       doy1_reg, doy2_reg;

    // Subtract and clamp to the signed output range.
    always_comb begin
        wide = signed'({1'b0, first_total}) - signed'({1'b0, second_total});
        if (wide > DIFF_MAX_WIDE) begin
            diff_next = DIFF_MAX;
        end else if (wide < DIFF_MIN_WIDE) begin
            diff_next = DIFF_MIN;
        end else begin
            diff_next = wide[DIFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load4) begin
            diff_reg <= diff_next;
            flag_reg <= not_later;
            doy1_reg <= first_doy;
            doy2_reg <= second_doy;
        end
    end

    assign day_difference     = diff_reg;
    assign first_not_later    = flag_reg;
    assign first_day_of_year  = doy1_reg;
    assign second_day_of_year = doy2_reg;

endmodule

>>> hdl/gregorian_date_difference.sv
// Top level of the Gregorian date difference pipeline.
//
//   Channel  Direction  Payload (lowest bit up)
//   s_       in         first_year, first_month, first_day, second_year, second_month,
//                       second_day, zero pad to 48 bits
//   m_       out        day_difference, first_not_later, first_day_of_year,
//                       second_day_of_year, zero pad to 48 bits
//
// One transfer per cycle in and out while m_tready does not stall the pipeline; the
// result passes through the four register stages (reciprocal and 365 products, leap
// terms, year count, subtract and clamp). Reset (aresetn low, synchronous) empties
// every stage.
// A stall on m_tready holds each full stage with no empty stage ahead of it in place;
// the others move on, empty stages keep filling, and s_tready falls only when all four stages hold an item.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gregorian_date_difference
    import gdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_year[13:0], first_month[17:14], first_day[22:18], second_year[36:23],
    // second_month[40:37], second_day[45:41], zero [47:46]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_difference[22:0], first_not_later[23], first_day_of_year[32:24],
    // second_day_of_year[41:33], zero [47:42]
    output logic [47:0] m_tdata
);

    pipe_ctrl_t ctrl;

    logic [YEAR_W-1:0]  first_year, second_year;
    logic [MONTH_W-1:0] first_month, second_month;
    logic [DAY_W-1:0]   first_day, second_day;

    logic [DAYS_W-1:0] first_total, second_total;
    logic [DOY_W-1:0]  first_doy, second_doy;

    logic              flag_next;
    logic              flag1_reg, flag2_reg, flag3_reg;

    logic [DIFF_W-1:0] day_difference;
    logic              first_not_later;
    logic [DOY_W-1:0]  first_day_of_year, second_day_of_year;

    // Unpack the input transfer.
    always_comb begin
        first_year   = s_tdata[13:0];
        first_month  = s_tdata[17:14];
        first_day    = s_tdata[22:18];
        second_year  = s_tdata[36:23];
        second_month = s_tdata[40:37];
        second_day   = s_tdata[45:41];
    end

    gdd_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    gdd_date_count u_first (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .year        (first_year),
        .month       (first_month),
        .day         (first_day),
        .total       (first_total),
        .day_of_year (first_doy)
    );

    gdd_date_count u_second (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .year        (second_year),
        .month       (second_month),
        .day         (second_day),
        .total       (second_total),
        .day_of_year (second_doy)
    );

    // Compare the raw fields, year first, and carry the flag alongside the counts.
    always_comb begin
        flag_next = (first_year < second_year) ||
                    (first_year == second_year && first_month < second_month) ||
                    (first_year == second_year && first_month == second_month &&
                     first_day <= second_day);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            flag1_reg <= flag_next;
        end
        if (ctrl.load2) begin
            flag2_reg <= flag1_reg;
        end
        if (ctrl.load3) begin
            flag3_reg <= flag2_reg;
        end
    end

    gdd_diff u_diff (
        .aclk               (aclk),
        .ctrl               (ctrl),
        .first_total        (first_total),
        .second_total       (second_total),
        .first_doy          (first_doy),
        .second_doy         (second_doy),
        .not_later          (flag3_reg),
        .day_difference     (day_difference),
        .first_not_later    (first_not_later),
        .first_day_of_year  (first_day_of_year),
        .second_day_of_year (second_day_of_year)
    );

    // Drive the handshake and pack the result transfer.
    assign s_tready = ctrl.load1;
    assign m_tvalid = ctrl.valid4;
    assign m_tdata  = {6'd0, second_day_of_year, first_day_of_year, first_not_later,
                       day_difference};

    // An accepted input transfer lands in stage one.
    `ASSERT_NEXT(a_enter_stage1, aclk, aresetn, s_tvalid && s_tready, ctrl.valid1)
    // A full stage one that cannot move keeps its item.
    `ASSERT_NEXT(a_hold_stage1, aclk, aresetn, ctrl.valid1 && !ctrl.load2, ctrl.valid1)
    // A full stage three moves into the output register when that register frees.
    `ASSERT_NEXT(a_move_to_output, aclk, aresetn, ctrl.valid3 && ctrl.load4, m_tvalid)
    // Input is refused only while the whole pipeline is full and stalled.
    `ASSERT_SAME(a_ready_when_room, aclk, aresetn, !s_tready,
                 ctrl.valid1 && ctrl.valid2 && ctrl.valid3 && m_tvalid && !m_tready)

endmodule

>>> tb/sv/gregorian_date_difference_test.sv
// Testbench for the Gregorian date difference pipeline: directed and random pairs.
`timescale 1ns / 1ps

module gregorian_date_difference_test;
    import gdd_pkg::*;

    localparam int unsigned RANDOM_PAIRS = 1300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam longint      SPAN_HIGH    = 4194303;
    localparam longint      SPAN_LOW     = -4194304;

    // One expected result of the block.
    typedef struct {
        logic signed [DIFF_W-1:0] span;
        logic                     first_not_later;
        logic [DOY_W-1:0]         doy_first;
        logic [DOY_W-1:0]         doy_second;
    } date_result_t;

    // Predicts the day span of each accepted date pair and checks the results in order.
    class date_board;
        date_result_t awaited[$];
        int unsigned  noted;
        int unsigned  checked;
        int unsigned  faults;

        function new();
            noted   = 0;
            checked = 0;
            faults  = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // Months past December run on at February length.
        static function int unsigned month_days(int unsigned m, bit leap);
            if (m == 2 || m > 12)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // Day field plus the lengths of every month ahead of it; month zero adds nothing.
        static function int unsigned ordinal(int unsigned y, int unsigned m, int unsigned d);
            int unsigned n;
            bit          leap;
            n    = d;
            leap = leap_year(y);
            for (int unsigned k = 1; k < m; k++)
                n += month_days(k, leap);
            return n;
        endfunction

        // Days in the years zero up to y-1, year zero counting as leap.
        static function longint days_to_year(longint y);
            return y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        function void note_input(logic [47:0] word);
            int unsigned  y1, y2;
            int unsigned  m1, m2;
            int unsigned  d1, d2;
            date_result_t r;
            longint       span;
            int unsigned  o1, o2;
            y1 = 32'(word[13:0]);
            m1 = 32'(word[17:14]);
            d1 = 32'(word[22:18]);
            y2 = 32'(word[36:23]);
            m2 = 32'(word[40:37]);
            d2 = 32'(word[45:41]);
            o1 = ordinal(y1, m1, d1);
            o2 = ordinal(y2, m2, d2);
            span = (days_to_year(longint'(y1)) + longint'(o1))
                 - (days_to_year(longint'(y2)) + longint'(o2));
            // Clamp spans that leave the signed output range.
            if (span > SPAN_HIGH)
                span = SPAN_HIGH;
            if (span < SPAN_LOW)
                span = SPAN_LOW;
            r.span            = DIFF_W'(span);
            r.first_not_later = (y1 < y2) || (y1 == y2 && m1 < m2) ||
                                (y1 == y2 && m1 == m2 && d1 <= d2);
            r.doy_first       = DOY_W'(o1);
            r.doy_second      = DOY_W'(o2);
            awaited.push_back(r);
            noted++;
        endfunction

        function void check_result(logic [47:0] word);
            date_result_t e;
            if (awaited.size() == 0) begin
                $error("result transfer with no date pair outstanding");
                faults++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (word[22:0] !== e.span) begin
                $error("day_difference: expected %0d, got %0d", e.span, $signed(word[22:0]));
                faults++;
            end
            if (word[23] !== e.first_not_later) begin
                $error("first_not_later: expected %0d, got %0d", e.first_not_later, word[23]);
                faults++;
            end
            if (word[32:24] !== e.doy_first) begin
                $error("first_day_of_year: expected %0d, got %0d", e.doy_first, word[32:24]);
                faults++;
            end
            if (word[41:33] !== e.doy_second) begin
                $error("second_day_of_year: expected %0d, got %0d", e.doy_second, word[41:33]);
                faults++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic        in_taken = 1'b0;
    bit          no_idle  = 1'b0;
    int unsigned pairs_sent = 0;
    int unsigned cycle_count = 0;
    date_board   board;

    gregorian_date_difference dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Note input transfers and check result transfers at each rising edge.
    always @(posedge aclk) begin
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_input(s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // Abort a run that hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, board.pending());
        $display("FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic logic [47:0] pack_dates(
        input int unsigned y1, input int unsigned m1, input int unsigned d1,
        input int unsigned y2, input int unsigned m2, input int unsigned d2
    );
        return {2'b00, DAY_W'(d2), MONTH_W'(m2), YEAR_W'(y2),
                DAY_W'(d1), MONTH_W'(m1), YEAR_W'(y1)};
    endfunction

    // Bias years toward centuries, multiples of four and the ends of 1 to 9999.
    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(1, 99) * 100;
        if (r == 1)
            return $urandom_range(1, 2499) * 4;
        if (r == 2)
            return ($urandom_range(0, 1) != 0) ? 9999 - $urandom_range(0, 3)
                                               : 1 + $urandom_range(0, 3);
        return $urandom_range(1, 9999);
    endfunction

    // Mostly valid date pairs, some close together; the rest raw noise over every field bit.
    function automatic logic [47:0] random_pair();
        int unsigned y1, m1, d1, y2, m2, d2;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            return pack_dates($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        y1 = pick_year();
        m1 = $urandom_range(1, 12);
        d1 = $urandom_range(1, date_board::month_days(m1, date_board::leap_year(y1)));
        y2 = pick_year();
        m2 = $urandom_range(1, 12);
        d2 = $urandom_range(1, date_board::month_days(m2, date_board::leap_year(y2)));
        kind = $urandom_range(0, 9);
        if (kind >= 4 && kind <= 6) begin
            y2 = y1;
        end else if (kind == 7) begin
            y2 = y1;
            m2 = m1;
            d2 = d1;
        end else if (kind == 8) begin
            y2 = y1;
            m2 = m1;
            d2 = (d1 > 1 && $urandom_range(0, 1) != 0) ? d1 - 1 : d1 + 1;
            if (d2 > date_board::month_days(m2, date_board::leap_year(y2)))
                d2 = d1;
        end else if (kind == 9) begin
            y2 = (y1 < 9999) ? y1 + 1 : y1 - 1;
            m2 = m1;
            d2 = (d1 > 28) ? 28 : d1;
        end
        return pack_dates(y1, m1, d1, y2, m2, d2);
    endfunction

    // Offer one pair after a random gap and hold it until the transfer.
    task automatic send_word(input logic [47:0] word);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        do
            @(negedge aclk);
        while (!in_taken);
        pairs_sent++;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    // Result side: runs of ready broken by random stalls.
    initial begin
        int unsigned stall;
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : pick_gap();
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    initial begin
        int unsigned directed;
        board = new();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Range ends in both orders, equal dates, leap rules.
        send_word(pack_dates(1, 1, 1, 9999, 12, 31));
        send_word(pack_dates(9999, 12, 31, 1, 1, 1));
        send_word(pack_dates(2024, 2, 29, 2024, 2, 29));
        send_word(pack_dates(2000, 3, 1, 2000, 2, 28));
        send_word(pack_dates(1900, 3, 1, 1900, 2, 28));
        send_word(pack_dates(2024, 3, 1, 2023, 3, 1));
        send_word(pack_dates(1600, 12, 31, 1601, 1, 1));
        send_word(pack_dates(9999, 12, 31, 9999, 12, 30));
        send_word(pack_dates(2010, 5, 1, 2010, 4, 30));
        // Month zero and day zero.
        send_word(pack_dates(2023, 0, 15, 2023, 1, 1));
        send_word(pack_dates(2023, 1, 0, 2023, 1, 1));
        send_word(pack_dates(0, 1, 1, 0, 0, 0));
        // Months past December, the largest ordinal day among them.
        send_word(pack_dates(2020, 15, 31, 2019, 15, 31));
        send_word(pack_dates(2019, 13, 5, 2019, 14, 5));
        // Year zero counts as leap.
        send_word(pack_dates(0, 3, 1, 1, 1, 1));
        // Spans past the output range clamp at both ends.
        send_word(pack_dates(16383, 15, 31, 0, 0, 0));
        send_word(pack_dates(0, 0, 0, 16383, 15, 31));
        send_word(pack_dates(16383, 15, 31, 16383, 15, 31));
        // Invalid dates: one pair where the order flag and the span sign disagree, one with a zero span.
        send_word(pack_dates(2021, 2, 31, 2021, 3, 1));
        send_word(pack_dates(2100, 2, 29, 2100, 3, 1));
        directed = pairs_sent;

        // Let the pipeline empty before the random part.
        s_tvalid = 1'b0;
        wait_drained();

        for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
            no_idle = (i >= 300 && i < 400) || (i >= 900 && i < 1000);
            if (i == RANDOM_PAIRS / 2) begin
                s_tvalid = 1'b0;
                wait_drained();
            end
            send_word(random_pair());
        end
        s_tvalid = 1'b0;
        no_idle  = 1'b0;

        wait_drained();
        repeat (10) @(negedge aclk);

        $display("Sent %0d date pairs (%0d directed) with gaps and stalls on both sides;",
                 pairs_sent, directed);
        $display("checked %0d results, %0d outstanding, %0d mismatches.",
                 board.checked, board.pending(), board.faults);
        if (board.faults == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/gdd_pkg.sv
hdl/gdd_pipe_ctrl.sv
hdl/gdd_date_count.sv
hdl/gdd_diff.sv
hdl/gregorian_date_difference.sv
tb/sv/gregorian_date_difference_test.sv
